>>> design/afc_pkg.sv
package afc_pkg;

  localparam int unsigned NUM_PLANES = 6;
  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned NUM_COMPS  = 4;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned REG_WIDTH  = 64;
  localparam int unsigned ADDR_WIDTH = 6;
  localparam int unsigned IDX_LSB    = 3;
  localparam int unsigned IDX_WIDTH  = ADDR_WIDTH - IDX_LSB;

  typedef logic [IDX_WIDTH-1:0] reg_idx_t;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_PLANE_LEFT   = 3'd0,
    REG_PLANE_RIGHT  = 3'd1,
    REG_PLANE_TOP    = 3'd2,
    REG_PLANE_BOTTOM = 3'd3,
    REG_PLANE_NEAR   = 3'd4,
    REG_PLANE_FAR    = 3'd5
  } reg_addr_e;

  typedef logic [NUM_PLANES-1:0][REG_WIDTH-1:0] plane_bank_t;

endpackage

>>> design/aabb_frustum_cull.sv
// Channel   Ports                                          Handshake
// request   start, busy, center_{x,y,z}_i, extent_{x,y,z}_i  start && !busy
// result    done_o, inside_res_o                           done_o, one cycle, no back pressure
// config    psel, penable, pwrite, paddr, pwdata, prdata   APB write at access phase
//
// One box is accepted every cycle; busy never rises.
// The result strobe follows the accepted request through the input register, the corner
// adder, the multiplier stage, the four-term adder with its sign test, and the output register.
// Reset clears the valid bits and the six plane registers; payload registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
module aabb_frustum_cull #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [COORD_WIDTH-1:0]           center_x_i,
  input  logic signed [COORD_WIDTH-1:0]           center_y_i,
  input  logic signed [COORD_WIDTH-1:0]           center_z_i,
  input  logic        [COORD_WIDTH-2:0]           extent_x_i,
  input  logic        [COORD_WIDTH-2:0]           extent_y_i,
  input  logic        [COORD_WIDTH-2:0]           extent_z_i,
  output logic                                    done_o,
  output logic                                    inside_res_o,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic        [afc_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic        [afc_pkg::REG_WIDTH-1:0]    pwdata,
  output logic        [afc_pkg::REG_WIDTH-1:0]    prdata,
  output logic                                    pready
);
  import afc_pkg::*;

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned CW    = W + 1;
  localparam int unsigned PW    = 2 * W + 1;
  localparam int unsigned AW    = (2 * W + 3 > REG_WIDTH) ? REG_WIDTH : 2 * W + 3;
  localparam int unsigned EXT_W = REG_WIDTH + NUM_COMPS * W;

  plane_bank_t plane_q;
  reg_idx_t    reg_idx;
  logic        wr_en;

  logic [EXT_W-1:0]     plane_ext [NUM_PLANES];
  logic signed [W-1:0]  comp      [NUM_PLANES][NUM_COMPS];

  logic                 s1_v_q;
  logic signed [W-1:0]  c_q  [NUM_AXES];
  logic [W-2:0]         e_q  [NUM_AXES];

  logic                 s2_v_q;
  logic signed [CW-1:0] lo_q [NUM_AXES];
  logic signed [CW-1:0] hi_q [NUM_AXES];

  logic                 s3_v_q;
  logic signed [PW-1:0] prod_q [NUM_PLANES][NUM_AXES];

  logic                 s4_v_q;
  logic [NUM_PLANES-1:0] outside_q;

  logic signed [AW-1:0] sum [NUM_PLANES];

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_WIDTH-1:IDX_LSB];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (reg_idx <= REG_PLANE_FAR) begin
      prdata = plane_q[reg_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (wr_en && (reg_idx <= REG_PLANE_FAR)) begin
      plane_q[reg_idx] <= pwdata;
    end
  end

  // Components that fall past the 64-bit register read as zero-padded bits.
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      plane_ext[p] = {{(NUM_COMPS * W){1'b0}}, plane_q[p]};
      for (int k = 0; k < NUM_COMPS; k++) begin
        comp[p][k] = plane_ext[p][k*W +: W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      s4_v_q    <= 1'b0;
      done_o    <= 1'b0;
    end else begin
      s1_v_q    <= start && !busy;
      s2_v_q    <= s1_v_q;
      s3_v_q    <= s2_v_q;
      s4_v_q    <= s3_v_q;
      done_o    <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q[0] <= center_x_i;
    c_q[1] <= center_y_i;
    c_q[2] <= center_z_i;
    e_q[0] <= extent_x_i;
    e_q[1] <= extent_y_i;
    e_q[2] <= extent_z_i;
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      lo_q[a] <= CW'(c_q[a]) - $signed({2'b00, e_q[a]});
      hi_q[a] <= CW'(c_q[a]) + $signed({2'b00, e_q[a]});
    end
  end

  // A negative normal component takes the max corner, otherwise the min corner.
  always_ff @(posedge clk_i) begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prod_q[p][a] <= PW'(comp[p][a]) * PW'(comp[p][a][W-1] ? hi_q[a] : lo_q[a]);
      end
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      sum[p] = AW'(prod_q[p][0]) + AW'(prod_q[p][1]) + AW'(prod_q[p][2])
             + (AW'(comp[p][3]) <<< FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      outside_q[p] <= !sum[p][AW-1] && (|sum[p]);
    end
    inside_res_o <= ~|outside_q;
  end

  a_valid_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> ##4 done_o)
    else $error("accepted request did not produce a result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 5))
    else $error("result without a matching request");

  a_bad_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (reg_idx > REG_PLANE_FAR)) |=> $stable(plane_q))
    else $error("write to an unused address changed a plane");

endmodule

>>> tb/aabb_frustum_cull_tb.sv
`timescale 1ns / 1ps

module aabb_frustum_cull_tb;
  import afc_pkg::*;

  localparam int CW = 16;
  localparam int EW = CW - 1;
  localparam int DRAIN_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int MAX_REPORTS = 10;
  localparam reg_idx_t IDX_SPARE_LO = 3'd6;
  localparam reg_idx_t IDX_SPARE_HI = 3'd7;
  localparam reg_addr_e PLANE_REGS [NUM_PLANES] = '{
    REG_PLANE_LEFT, REG_PLANE_RIGHT, REG_PLANE_TOP,
    REG_PLANE_BOTTOM, REG_PLANE_NEAR, REG_PLANE_FAR
  };

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] center_x = '0;
  logic signed [CW-1:0] center_y = '0;
  logic signed [CW-1:0] center_z = '0;
  logic [EW-1:0] extent_x = '0;
  logic [EW-1:0] extent_y = '0;
  logic [EW-1:0] extent_z = '0;
  logic done;
  logic inside_res;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [REG_WIDTH-1:0] pwdata = '0;
  logic [REG_WIDTH-1:0] prdata;
  logic pready;

  logic [REG_WIDTH-1:0] plane_model [NUM_PLANES];
  bit inside_q [$];
  bit idling_on = 1'b1;
  bit want_inside;
  int mismatch_count = 0;
  int boxes_checked = 0;
  int quiet_cycles = 0;

  aabb_frustum_cull #(
    .COORD_WIDTH(CW)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .center_x_i  (center_x),
    .center_y_i  (center_y),
    .center_z_i  (center_z),
    .extent_x_i  (extent_x),
    .extent_y_i  (extent_y),
    .extent_z_i  (extent_z),
    .done_o      (done),
    .inside_res_o(inside_res),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      plane_model[p] = '0;
    end
  end

  function automatic longint plane_comp(logic [REG_WIDTH-1:0] plane, int k);
    return longint'($signed(plane[k*CW +: CW]));
  endfunction

  function automatic bit predict_inside(logic signed [CW-1:0] cx, cy, cz,
                                        logic [EW-1:0] ex, ey, ez);
    longint lo [NUM_AXES];
    longint hi [NUM_AXES];
    longint acc;
    longint n;
    bit in_view = 1'b1;
    lo[0] = longint'(cx) - longint'(ex);
    lo[1] = longint'(cy) - longint'(ey);
    lo[2] = longint'(cz) - longint'(ez);
    hi[0] = longint'(cx) + longint'(ex);
    hi[1] = longint'(cy) + longint'(ey);
    hi[2] = longint'(cz) + longint'(ez);
    for (int p = 0; p < NUM_PLANES; p++) begin
      acc = plane_comp(plane_model[p], 3) <<< FRAC_BITS;
      for (int a = 0; a < NUM_AXES; a++) begin
        n = plane_comp(plane_model[p], a);
        acc += n * ((n < 0) ? hi[a] : lo[a]);
      end
      if (acc > 0) begin
        in_view = 1'b0;
      end
    end
    return in_view;
  endfunction

  function automatic logic [REG_WIDTH-1:0] pack_plane(int x, int y, int z, int w);
    return {w[CW-1:0], z[CW-1:0], y[CW-1:0], x[CW-1:0]};
  endfunction

  // Expectations are queued and results checked in one process, so a result can
  // never race the request that caused it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        inside_q.push_back(predict_inside(center_x, center_y, center_z,
                                          extent_x, extent_y, extent_z));
      end
      if (done) begin
        if (inside_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected result: inside=%0b", inside_res);
          end
        end else begin
          want_inside = inside_q.pop_front();
          if (inside_res !== want_inside) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("box %0d: expected inside=%0b, got %0b",
                       boxes_checked, want_inside, inside_res);
            end
          end
        end
        boxes_checked++;
      end
    end
    if ((start && !busy) || done || (psel && penable && pwrite && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [REG_WIDTH-1:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_WIDTH'(idx) << IDX_LSB;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < NUM_PLANES) begin
      plane_model[idx] = value;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_box(int cx, int cy, int cz, int ex, int ey, int ez);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start <= 1'b1;
    center_x <= CW'(cx);
    center_y <= CW'(cy);
    center_z <= CW'(cz);
    extent_x <= EW'(ex);
    extent_y <= EW'(ey);
    extent_z <= EW'(ez);
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random_box(bit near_origin);
    int c [NUM_AXES];
    int e [NUM_AXES];
    for (int k = 0; k < NUM_AXES; k++) begin
      if (near_origin) begin
        c[k] = int'($urandom_range(0, 12000)) - 6000;
        e[k] = int'($urandom_range(0, 1500));
      end else begin
        c[k] = int'($urandom());
        e[k] = int'($urandom());
      end
    end
    send_box(c[0], c[1], c[2], e[0], e[1], e[2]);
  endtask

  task automatic finish_phase();
    start <= 1'b0;
    while (inside_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Outward normals: a box is culled when even its most inward corner lies
  // past one of the planes.
  task automatic load_random_frustum();
    int comp [NUM_AXES];
    int sgn;
    for (int i = 0; i < NUM_PLANES; i++) begin
      sgn = (i % 2 == 1) ? 1 : -1;
      for (int k = 0; k < NUM_AXES; k++) begin
        if (k == i / 2) begin
          comp[k] = sgn * int'($urandom_range(128, 512));
        end else begin
          comp[k] = int'($urandom_range(0, 128)) - 64;
        end
      end
      cfg_write(PLANE_REGS[i], pack_plane(comp[0], comp[1], comp[2],
                                          -int'($urandom_range(1024, 8192))));
    end
  endtask

  task automatic test_reset_planes();
    send_box(32767, 32767, 32767, 32767, 32767, 32767);
    send_box(-32768, -32768, -32768, 0, 0, 0);
    send_box(0, 0, 0, 0, 0, 0);
    send_box(-32768, 32767, -1, 32767, 0, 1);
    finish_phase();
  endtask

  task automatic test_extreme_planes();
    int vals [3] = '{32767, -32768, -1};
    foreach (vals[j]) begin
      foreach (PLANE_REGS[i]) begin
        cfg_write(PLANE_REGS[i], pack_plane(vals[j], vals[j], vals[j], vals[j]));
      end
      send_box(32767, 32767, 32767, 0, 0, 0);
      send_box(-32768, -32768, -32768, 32767, 32767, 32767);
      finish_phase();
    end
  endtask

  task automatic test_zero_normals();
    foreach (PLANE_REGS[i]) begin
      cfg_write(PLANE_REGS[i], pack_plane(0, 0, 0, 1));
    end
    send_box(0, 0, 0, 0, 0, 0);
    finish_phase();
    foreach (PLANE_REGS[i]) begin
      cfg_write(PLANE_REGS[i], '0);
    end
    cfg_write(REG_PLANE_LEFT, pack_plane(0, 256, 0, 0));
    send_box(0, 512, 0, 0, 256, 0);
    send_box(-20000, 0, 20000, 0, 0, 0);
    finish_phase();
  endtask

  task automatic test_cube_edges();
    cfg_write(REG_PLANE_LEFT, pack_plane(-256, 0, 0, -4096));
    cfg_write(REG_PLANE_RIGHT, pack_plane(256, 0, 0, -4096));
    cfg_write(REG_PLANE_TOP, pack_plane(0, -256, 0, -4096));
    cfg_write(REG_PLANE_BOTTOM, pack_plane(0, 256, 0, -4096));
    cfg_write(REG_PLANE_NEAR, pack_plane(0, 0, -256, -4096));
    cfg_write(REG_PLANE_FAR, pack_plane(0, 0, 256, -4096));
    send_box(0, 0, 0, 100, 100, 100);
    send_box(4196, 0, 0, 100, 0, 0);
    send_box(4196, 0, 0, 99, 0, 0);
    send_box(-4196, 0, 0, 99, 0, 0);
    send_box(0, -4196, 0, 0, 100, 0);
    send_box(0, 0, 4196, 0, 0, 99);
    send_box(0, 0, 0, 32767, 32767, 32767);
    finish_phase();
    // Writes to addresses past the last plane must leave the planes untouched.
    cfg_write(IDX_SPARE_LO, '1);
    cfg_write(IDX_SPARE_HI, '1);
    send_box(4196, 0, 0, 99, 0, 0);
    send_box(4196, 0, 0, 100, 0, 0);
    finish_phase();
  endtask

  task automatic test_random_planes();
    for (int r = 0; r < 2; r++) begin
      foreach (PLANE_REGS[i]) begin
        cfg_write(PLANE_REGS[i], {$urandom(), $urandom()});
      end
      repeat (20) send_random_box($urandom_range(0, 1) == 0);
      finish_phase();
    end
  endtask

  task automatic test_random_frustums();
    for (int r = 0; r < 4; r++) begin
      load_random_frustum();
      repeat (80) send_random_box($urandom_range(0, 3) != 0);
      finish_phase();
    end
  endtask

  task automatic test_steady_stream();
    idling_on = 1'b0;
    load_random_frustum();
    repeat (100) send_random_box($urandom_range(0, 3) != 0);
    finish_phase();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_planes();
    test_extreme_planes();
    test_zero_normals();
    test_cube_edges();
    test_random_planes();
    test_random_frustums();
    test_steady_stream();
    mismatch_count += inside_q.size();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> aabb_frustum_cull.f
design/afc_pkg.sv
design/aabb_frustum_cull.sv
tb/aabb_frustum_cull_tb.sv
